[rtl/core/wsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and codes for the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OPCODE = 2'd1,
    ST_LEN64  = 2'd2,
    ST_TRUNC  = 2'd3
  } status_t;

  localparam logic [3:0] OPCODE_TEXT = 4'h1;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    status_t     status;
    logic [15:0] frame_length;
  } wsd_result_t;

endpackage
`default_nettype wire

[rtl/core/wsd_parse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_parse
// header state machine and payload unmasking, one byte per transfer
// ----------------------------------------------------------------------------
module wsd_parse (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 end_of_buffer,
  output wsd_pkg::wsd_result_t      res,
  output logic                      res_valid
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTHI,
    PH_EXTLO,
    PH_KEY,
    PH_DATA,
    PH_DRAIN
  } phase_t;

  phase_t      phase, phase_next;
  logic        masked, masked_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_bytes_seen, key_bytes_seen_next;
  logic [15:0] remaining_length, remaining_length_next;
  logic [15:0] total_length, total_length_next;
  logic [1:0]  key_index, key_index_next;
  logic [3:0]  opcode_seen, opcode_seen_next;

  always_comb begin
    logic [6:0] len7;
    logic       hdr_end;
    len7 = data_byte[6:0];
    hdr_end = 1'b0;

    phase_next            = phase;
    masked_next           = masked;
    mask_key_next         = mask_key;
    key_bytes_seen_next   = key_bytes_seen;
    remaining_length_next = remaining_length;
    total_length_next     = total_length;
    key_index_next        = key_index;
    opcode_seen_next      = opcode_seen;

    res.out_byte     = '0;
    res.byte_valid   = 1'b0;
    res.last         = 1'b0;
    res.status       = ST_OK;
    res.frame_length = '0;

    unique case (phase)
      PH_HDR0: begin
        opcode_seen_next      = data_byte[3:0];
        masked_next           = 1'b0;
        mask_key_next         = '0;
        key_bytes_seen_next   = '0;
        key_index_next        = '0;
        total_length_next     = '0;
        remaining_length_next = '0;
        phase_next            = PH_HDR1;
      end
      PH_HDR1: begin
        masked_next = data_byte[7];
        if (opcode_seen != OPCODE_TEXT) begin
          res.last   = 1'b1;
          res.status = ST_OPCODE;
          phase_next = PH_DRAIN;
        end else if (len7 == LEN7_EXT64) begin
          res.last   = 1'b1;
          res.status = ST_LEN64;
          phase_next = PH_DRAIN;
        end else if (len7 == LEN7_EXT16) begin
          phase_next = PH_EXTHI;
        end else begin
          total_length_next = {9'd0, len7};
          hdr_end = 1'b1;
        end
      end
      PH_EXTHI: begin
        total_length_next = {data_byte, 8'd0};
        phase_next        = PH_EXTLO;
      end
      PH_EXTLO: begin
        total_length_next = {total_length[15:8], data_byte};
        hdr_end = 1'b1;
      end
      PH_KEY: begin
        mask_key_next       = mask_key | ({24'd0, data_byte} << {key_bytes_seen, 3'b000});
        key_bytes_seen_next = key_bytes_seen + 2'd1;
        if (key_bytes_seen == 2'd3) begin
          remaining_length_next = total_length;
          key_index_next        = '0;
          if (total_length == '0) begin
            res.last   = 1'b1;
            phase_next = PH_DRAIN;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res.out_byte          = data_byte ^ mask_key[{key_index, 3'b000} +: 8];
        res.byte_valid        = 1'b1;
        key_index_next        = key_index + 2'd1;
        remaining_length_next = remaining_length - 16'd1;
        if (remaining_length_next == '0) begin
          res.last         = 1'b1;
          res.frame_length = total_length;
          phase_next       = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        phase_next = PH_DRAIN;
      end
      default: begin
        phase_next = PH_DRAIN;
      end
    endcase

    // header complete: key bytes next, straight to payload, or done if the payload is empty
    if (hdr_end) begin
      if (masked_next) begin
        key_bytes_seen_next = '0;
        phase_next          = PH_KEY;
      end else begin
        remaining_length_next = total_length_next;
        key_index_next        = '0;
        if (total_length_next == '0) begin
          res.last   = 1'b1;
          phase_next = PH_DRAIN;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end

    // end of buffer rearms; an unfinished frame is truncated
    if (end_of_buffer) begin
      if (phase_next != PH_DRAIN) begin
        res.last         = 1'b1;
        res.status       = ST_TRUNC;
        res.frame_length = '0;
      end
      phase_next = PH_HDR0;
    end

    res_valid = accept && (res.byte_valid || res.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      masked           <= 1'b0;
      mask_key         <= '0;
      key_bytes_seen   <= '0;
      remaining_length <= '0;
      total_length     <= '0;
      key_index        <= '0;
      opcode_seen      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      masked           <= masked_next;
      mask_key         <= mask_key_next;
      key_bytes_seen   <= key_bytes_seen_next;
      remaining_length <= remaining_length_next;
      total_length     <= total_length_next;
      key_index        <= key_index_next;
      opcode_seen      <= opcode_seen_next;
    end
  end

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |=> phase == PH_DRAIN || phase == PH_HDR0)
    else $error("frame not closed after final result");

  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DRAIN && !end_of_buffer |-> !res_valid)
    else $error("result while draining");

  a_eob_rearms: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_buffer |=> phase == PH_HDR0)
    else $error("parser not rearmed at end of buffer");

  a_error_final: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.last && res.frame_length == '0)
    else $error("error status on non-final result");

endmodule
`default_nettype wire

[rtl/core/wsd_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_out_buf
// result register with a skid entry that takes one more result under stall
// ----------------------------------------------------------------------------
module wsd_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wsd_pkg::wsd_result_t      push_data,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wsd_pkg::wsd_result_t      out_data
);
  import wsd_pkg::*;

  logic        main_valid;
  logic        skid_valid;
  wsd_result_t main_data;
  wsd_result_t skid_data;
  logic        pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry without result entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !pop |=> skid_valid && main_valid)
    else $error("buffered result lost");

  a_pop_refills: assert property (@(posedge clk) disable iff (rst)
    skid_valid && pop |=> main_valid && !skid_valid)
    else $error("skid entry not moved to result entry");

endmodule
`default_nettype wire

[rtl/core/websocket_frame_deframer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// parses one websocket text frame per buffer and unmasks its payload bytes
// ----------------------------------------------------------------------------
//   channel   ports                                          direction
//   input     in_valid, in_stall, data_byte, end_of_buffer   in, stall out
//   result    out_valid, out_stall, out_byte, byte_valid,    out, stall in
//             last, status, frame_length
//
// one byte per cycle while in_stall is low; each result is registered in the result buffer
// header state lives in the parser registers, the result in a two-entry buffer
// in_stall rises only when both result entries are held by out_stall
// synchronous reset returns the parser to the first header byte
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             last,
  output logic [1:0]       status,
  output logic [15:0]      frame_length
);
  import wsd_pkg::*;

  logic        accept;
  logic        res_valid;
  logic        buf_full;
  wsd_result_t res;
  wsd_result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  wsd_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .res           (res),
    .res_valid     (res_valid)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte     = out_data.out_byte;
  assign byte_valid   = out_data.byte_valid;
  assign last         = out_data.last;
  assign status       = out_data.status;
  assign frame_length = out_data.frame_length;

endmodule
`default_nettype wire

[test/websocket_frame_deframer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_checker
// follows every input transfer with its own frame parser, queues the result
// it should cause, and compares each result transfer with the oldest entry
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        byte_valid,
  input  logic        last,
  input  logic [1:0]  status,
  input  logic [15:0] frame_length,
  output int          errors,
  output int          pending,
  output int          results_checked,
  output int          frames_ok,
  output int          frames_failed
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    HDR_OPCODE,
    HDR_LENGTH,
    EXT_HIGH,
    EXT_LOW,
    MASK_KEY,
    PAYLOAD,
    SKIP_REST
  } parse_phase_t;

  parse_phase_t ph;
  logic         is_masked;
  logic [31:0]  key;
  logic [1:0]   key_cnt;
  logic [1:0]   key_pos;
  logic [15:0]  left_len;
  logic [15:0]  frame_len;
  logic [3:0]   opcode;

  wsd_result_t  deframed_q[$];

  task automatic deframe_byte(input logic [7:0] d, input logic eob);
    logic        emit;
    logic        done;
    logic        to_payload;
    status_t     st;
    logic [15:0] flen;
    logic [7:0]  ob;
    wsd_result_t r;
    emit = 1'b0;
    done = 1'b0;
    to_payload = 1'b0;
    st = ST_OK;
    flen = '0;
    ob = '0;
    case (ph)
      HDR_OPCODE: begin
        opcode = d[3:0];
        is_masked = 1'b0;
        key = '0;
        key_cnt = '0;
        key_pos = '0;
        frame_len = '0;
        left_len = '0;
        ph = HDR_LENGTH;
      end
      HDR_LENGTH: begin
        is_masked = d[7];
        if (opcode != OPCODE_TEXT) begin
          done = 1'b1;
          st = ST_OPCODE;
          ph = SKIP_REST;
        end else if (d[6:0] == LEN7_EXT64) begin
          done = 1'b1;
          st = ST_LEN64;
          ph = SKIP_REST;
        end else if (d[6:0] == LEN7_EXT16) begin
          ph = EXT_HIGH;
        end else begin
          frame_len = {9'd0, d[6:0]};
          if (is_masked) begin
            key_cnt = '0;
            ph = MASK_KEY;
          end else begin
            to_payload = 1'b1;
          end
        end
      end
      EXT_HIGH: begin
        frame_len = {d, 8'd0};
        ph = EXT_LOW;
      end
      EXT_LOW: begin
        frame_len[7:0] = d;
        if (is_masked) begin
          key_cnt = '0;
          ph = MASK_KEY;
        end else begin
          to_payload = 1'b1;
        end
      end
      MASK_KEY: begin
        key[8*key_cnt +: 8] = key[8*key_cnt +: 8] | d;
        key_cnt = key_cnt + 2'd1;
        if (key_cnt == 2'd0) to_payload = 1'b1;
      end
      PAYLOAD: begin
        ob = d ^ key[8*key_pos +: 8];
        emit = 1'b1;
        key_pos = key_pos + 2'd1;
        left_len = left_len - 16'd1;
        if (left_len == 16'd0) begin
          done = 1'b1;
          st = ST_OK;
          flen = frame_len;
          ph = SKIP_REST;
        end
      end
      default: ph = SKIP_REST;
    endcase

    if (to_payload) begin
      left_len = frame_len;
      key_pos = '0;
      if (frame_len == 16'd0) begin
        done = 1'b1;
        st = ST_OK;
        ph = SKIP_REST;
      end else begin
        ph = PAYLOAD;
      end
    end

    // end of buffer always rearms; an unfinished frame reports truncation
    if (eob) begin
      if (ph != SKIP_REST) begin
        done = 1'b1;
        st = ST_TRUNC;
        flen = '0;
      end
      ph = HDR_OPCODE;
    end

    if (emit || done) begin
      r.out_byte = ob;
      r.byte_valid = emit;
      r.last = done;
      r.status = st;
      r.frame_length = flen;
      deframed_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    wsd_result_t want;
    if (rst) begin
      ph = HDR_OPCODE;
      is_masked = 1'b0;
      key = '0;
      key_cnt = '0;
      key_pos = '0;
      left_len = '0;
      frame_len = '0;
      opcode = '0;
      deframed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (deframed_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result at %0t: byte %02h valid %b last %b status %0d len %0d",
                     $time, out_byte, byte_valid, last, status, frame_length);
        end else begin
          want = deframed_q.pop_front();
          if (out_byte !== want.out_byte || byte_valid !== want.byte_valid ||
              last !== want.last || status !== want.status ||
              frame_length !== want.frame_length) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: expected byte %02h valid %b last %b status %0d len %0d",
                       $time, want.out_byte, want.byte_valid, want.last, want.status,
                       want.frame_length);
              $display("                  got byte %02h valid %b last %b status %0d len %0d",
                       out_byte, byte_valid, last, status, frame_length);
            end
          end
          if (want.last) begin
            if (want.status == ST_OK) frames_ok++;
            else frames_failed++;
          end
        end
      end
      if (in_valid && !in_stall) deframe_byte(data_byte, end_of_buffer);
    end
    pending = deframed_q.size();
  end

endmodule

[test/tb_websocket_frame_deframer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit
// drives received buffers into the deframer, directed header and payload
// corner cases first, then random frames under four flow-control mixes
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit;
  import wsd_pkg::*;

  localparam int         IDLE_LIMIT    = 2000;
  localparam logic [3:0] OPCODE_BINARY = 4'h2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [1:0]  status;
  logic [15:0] frame_length;

  int errors;
  int pending;
  int results_checked;
  int frames_ok;
  int frames_failed;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int quiet_cycles = 0;

  logic [7:0] buf_bytes[$];

  websocket_frame_deframer_unit dut (.*);

  websocket_frame_deframer_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // no transfer on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_buffer();
    int i;
    for (i = 0; i < buf_bytes.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= buf_bytes[i];
      end_of_buffer <= (i == buf_bytes.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    buffers_sent++;
  endtask

  task automatic make_random_buffer();
    int         pick;
    int         len;
    int         cap;
    int         cut;
    int         i;
    logic       ext;
    logic       len64;
    logic       msk;
    logic [3:0] opc;
    logic [3:0] hi_bits;
    logic [7:0] rnd;
    buf_bytes.delete();
    if ($urandom_range(99) < 8) begin
      // plain noise
      repeat ($urandom_range(6, 1)) begin
        rnd = 8'($urandom_range(255));
        buf_bytes.push_back(rnd);
      end
      return;
    end
    opc = OPCODE_TEXT;
    if ($urandom_range(99) >= 85) opc = 4'($urandom_range(15));
    hi_bits = 4'($urandom_range(15));
    msk = ($urandom_range(99) < 60);
    ext = 1'b0;
    len64 = 1'b0;
    cap = 125;
    pick = $urandom_range(99);
    if (pick < 50) begin
      len = $urandom_range(12, 0);
    end else if (pick < 60) begin
      len = $urandom_range(125, 0);
    end else if (pick < 80) begin
      ext = 1'b1;
      len = $urandom_range(40, 0);
    end else if (pick < 93) begin
      ext = 1'b1;
      len = $urandom_range(65535, 0);
      cap = 16;
    end else begin
      len64 = 1'b1;
      len = 0;
    end

    buf_bytes.push_back({hi_bits, opc});
    if (len64) begin
      buf_bytes.push_back({msk, LEN7_EXT64});
      repeat ($urandom_range(8, 0)) begin
        rnd = 8'($urandom_range(255));
        buf_bytes.push_back(rnd);
      end
    end else begin
      if (ext) begin
        buf_bytes.push_back({msk, LEN7_EXT16});
        buf_bytes.push_back(len[15:8]);
        buf_bytes.push_back(len[7:0]);
      end else begin
        buf_bytes.push_back({msk, len[6:0]});
      end
      if (msk) begin
        repeat (4) begin
          rnd = 8'($urandom_range(255));
          buf_bytes.push_back(rnd);
        end
      end
      for (i = 0; i < len && i < cap; i++) begin
        rnd = 8'($urandom_range(255));
        buf_bytes.push_back(rnd);
      end
    end

    if (len > cap || $urandom_range(99) < 25) begin
      cut = $urandom_range(buf_bytes.size(), 1);
      while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
    end else begin
      repeat ($urandom_range(2, 0)) begin
        rnd = 8'($urandom_range(255));
        buf_bytes.push_back(rnd);
      end
    end
  endtask

  task automatic run_random(input int idle_chance, input int stall_chance, input int n_bytes);
    int stop;
    send_idle_pct = idle_chance;
    stall_pct = stall_chance;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      make_random_buffer();
      send_buffer();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // non-text opcode, then a byte that must be ignored
    buf_bytes = '{{4'h8, OPCODE_BINARY}, 8'h05, 8'hAA};
    send_buffer();
    // 64-bit length
    buf_bytes = '{{4'h8, OPCODE_TEXT}, {1'b0, LEN7_EXT64}};
    send_buffer();
    // empty payload, fin clear
    buf_bytes = '{{4'h0, OPCODE_TEXT}, 8'h00};
    send_buffer();
    // masked short extended length, rsv set, one trailing byte
    buf_bytes = '{{4'hF, OPCODE_TEXT}, {1'b1, LEN7_EXT16}, 8'h00, 8'h02,
                  8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF};
    send_buffer();
    // buffer ends inside the payload
    buf_bytes = '{{4'h8, OPCODE_TEXT}, 8'h03, 8'h41};
    send_buffer();
    // buffer ends inside the header
    buf_bytes = '{{4'h8, OPCODE_TEXT}};
    send_buffer();

    run_random(0, 0, 175);
    run_random(45, 0, 175);
    run_random(0, 45, 175);
    run_random(36, 36, 175);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d bytes in %0d buffers over four flow-control mixes",
             bytes_sent, buffers_sent);
    $display("checked %0d results: %0d frames complete, %0d ended in an error status",
             results_checked, frames_ok, frames_failed);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/wsd_pkg.sv
rtl/core/wsd_parse.sv
rtl/core/wsd_out_buf.sv
rtl/core/websocket_frame_deframer_unit.sv
test/websocket_frame_deframer_checker.sv
test/tb_websocket_frame_deframer_unit.sv
